@@ rtl/core/rv32ienc_pkg.sv @@
// RV32I encoder package: request/result types, format codes and the opcode table.
// Used by rv32ienc_encode and rv32i_instruction_encoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rv32ienc_pkg;

    localparam int unsigned CmdWidth  = 6;
    localparam int unsigned RegWidth  = 5;
    localparam int unsigned ImmWidth  = 32;
    localparam int unsigned MaskWidth = 4;
    localparam int unsigned WordWidth = 32;
    localparam int unsigned ErrWidth  = 2;

    typedef enum logic [2:0] {
        FMT_NONE  = 3'd0,
        FMT_U     = 3'd1,
        FMT_J     = 3'd2,
        FMT_I     = 3'd3,
        FMT_B     = 3'd4,
        FMT_S     = 3'd5,
        FMT_R     = 3'd6,
        FMT_FENCE = 3'd7
    } fmt_t;

    typedef enum logic [ErrWidth-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_ALIGN = 2'd2
    } err_t;

    typedef enum logic [CmdWidth-1:0] {
        CMD_LUI    = 6'd0,  CMD_AUIPC  = 6'd1,  CMD_JAL    = 6'd2,  CMD_JALR   = 6'd3,
        CMD_BEQ    = 6'd4,  CMD_BNE    = 6'd5,  CMD_BLT    = 6'd6,  CMD_BGE    = 6'd7,
        CMD_BLTU   = 6'd8,  CMD_BGEU   = 6'd9,  CMD_LB     = 6'd10, CMD_LH     = 6'd11,
        CMD_LW     = 6'd12, CMD_LBU    = 6'd13, CMD_LHU    = 6'd14, CMD_SB     = 6'd15,
        CMD_SH     = 6'd16, CMD_SW     = 6'd17, CMD_ADDI   = 6'd18, CMD_SLTI   = 6'd19,
        CMD_SLTIU  = 6'd20, CMD_XORI   = 6'd21, CMD_ORI    = 6'd22, CMD_ANDI   = 6'd23,
        CMD_SLLI   = 6'd24, CMD_SRLI   = 6'd25, CMD_SRAI   = 6'd26, CMD_ADD    = 6'd27,
        CMD_SUB    = 6'd28, CMD_SLL    = 6'd29, CMD_SLT    = 6'd30, CMD_SLTU   = 6'd31,
        CMD_XOR    = 6'd32, CMD_SRL    = 6'd33, CMD_SRA    = 6'd34, CMD_OR     = 6'd35,
        CMD_AND    = 6'd36, CMD_FENCE  = 6'd37, CMD_ECALL  = 6'd38, CMD_EBREAK = 6'd39
    } cmd_t;

    typedef struct packed {
        logic [MaskWidth-1:0] fence_succ;
        logic [MaskWidth-1:0] fence_pred;
        logic [ImmWidth-1:0]  immediate;
        logic [RegWidth-1:0]  src2_reg;
        logic [RegWidth-1:0]  src1_reg;
        logic [RegWidth-1:0]  dest_reg;
        logic [CmdWidth-1:0]  command;
    } request_t;

    typedef struct packed {
        logic [ErrWidth-1:0]  error_code;
        logic [WordWidth-1:0] machine_word;
    } result_t;

    typedef struct packed {
        logic [WordWidth-1:0] base;
        fmt_t                 fmt;
    } op_entry_t;

    function automatic op_entry_t op_lookup(input logic [CmdWidth-1:0] cmd);
        op_entry_t e;
        e = '{base: 32'h0000_0000, fmt: FMT_NONE};
        case (cmd)
            CMD_LUI:    e = '{32'h0000_0037, FMT_U};
            CMD_AUIPC:  e = '{32'h0000_0017, FMT_U};
            CMD_JAL:    e = '{32'h0000_006F, FMT_J};
            CMD_JALR:   e = '{32'h0000_0067, FMT_I};
            CMD_BEQ:    e = '{32'h0000_0063, FMT_B};
            CMD_BNE:    e = '{32'h0000_1063, FMT_B};
            CMD_BLT:    e = '{32'h0000_4063, FMT_B};
            CMD_BGE:    e = '{32'h0000_5063, FMT_B};
            CMD_BLTU:   e = '{32'h0000_6063, FMT_B};
            CMD_BGEU:   e = '{32'h0000_7063, FMT_B};
            CMD_LB:     e = '{32'h0000_0003, FMT_I};
            CMD_LH:     e = '{32'h0000_1003, FMT_I};
            CMD_LW:     e = '{32'h0000_2003, FMT_I};
            CMD_LBU:    e = '{32'h0000_4003, FMT_I};
            CMD_LHU:    e = '{32'h0000_5003, FMT_I};
            CMD_SB:     e = '{32'h0000_0023, FMT_S};
            CMD_SH:     e = '{32'h0000_1023, FMT_S};
            CMD_SW:     e = '{32'h0000_2023, FMT_S};
            CMD_ADDI:   e = '{32'h0000_0013, FMT_I};
            CMD_SLTI:   e = '{32'h0000_2013, FMT_I};
            CMD_SLTIU:  e = '{32'h0000_3013, FMT_I};
            CMD_XORI:   e = '{32'h0000_4013, FMT_I};
            CMD_ORI:    e = '{32'h0000_6013, FMT_I};
            CMD_ANDI:   e = '{32'h0000_7013, FMT_I};
            CMD_SLLI:   e = '{32'h0000_1013, FMT_R};
            CMD_SRLI:   e = '{32'h0000_5013, FMT_R};
            CMD_SRAI:   e = '{32'h4000_5013, FMT_R};
            CMD_ADD:    e = '{32'h0000_0033, FMT_R};
            CMD_SUB:    e = '{32'h4000_0033, FMT_R};
            CMD_SLL:    e = '{32'h0000_1033, FMT_R};
            CMD_SLT:    e = '{32'h0000_2033, FMT_R};
            CMD_SLTU:   e = '{32'h0000_3033, FMT_R};
            CMD_XOR:    e = '{32'h0000_4033, FMT_R};
            CMD_SRL:    e = '{32'h0000_5033, FMT_R};
            CMD_SRA:    e = '{32'h4000_5033, FMT_R};
            CMD_OR:     e = '{32'h0000_6033, FMT_R};
            CMD_AND:    e = '{32'h0000_7033, FMT_R};
            CMD_FENCE:  e = '{32'h0000_000F, FMT_FENCE};
            CMD_ECALL:  e = '{32'h0000_0073, FMT_NONE};
            CMD_EBREAK: e = '{32'h0010_0073, FMT_NONE};
            default:    e = '{32'h0000_0000, FMT_NONE};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rv32ienc_encode.sv @@
// RV32I encoder datapath: format select, immediate range check and bit scatter.
// Purely combinational; depends on rv32ienc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rv32ienc_encode (
    input  rv32ienc_pkg::request_t req,
    output rv32ienc_pkg::result_t  res
);
    import rv32ienc_pkg::*;

    op_entry_t            op;
    logic [ImmWidth-1:0]  imm;
    logic                 fits12;
    logic                 fits13;
    logic                 fits21;
    logic                 fits_u;
    logic [WordWidth-1:0] word;
    err_t                 err;

    assign op  = op_lookup(req.command);
    assign imm = req.immediate;

    // signed fit: all bits above the field equal the sign bit
    assign fits12 = (imm[31:11] == {21{imm[31]}});
    assign fits13 = (imm[31:12] == {20{imm[31]}});
    assign fits21 = (imm[31:20] == {12{imm[31]}});
    // lui/auipc: 20 bits read as signed or unsigned
    assign fits_u = (imm[31:20] == 12'h000) || (imm[31:19] == 13'h1FFF);

    always_comb begin
        word = op.base;
        err  = ERR_OK;
        unique case (op.fmt)
            FMT_U: begin
                if (!fits_u) begin
                    err = ERR_RANGE;
                end else begin
                    word = op.base | {imm[19:0], req.dest_reg, 7'b0};
                end
            end
            FMT_J: begin
                if (!fits21) begin
                    err = ERR_RANGE;
                end else if (imm[0]) begin
                    err = ERR_ALIGN;
                end else begin
                    word = op.base | {imm[20], imm[10:1], imm[11], imm[19:12],
                                      req.dest_reg, 7'b0};
                end
            end
            FMT_I: begin
                if (!fits12) begin
                    err = ERR_RANGE;
                end else begin
                    word = op.base | {imm[11:0], req.src1_reg, 3'b0, req.dest_reg, 7'b0};
                end
            end
            FMT_B: begin
                if (!fits13) begin
                    err = ERR_RANGE;
                end else if (imm[0]) begin
                    err = ERR_ALIGN;
                end else begin
                    word = op.base | {imm[12], imm[10:5], req.src2_reg, req.src1_reg, 3'b0,
                                      imm[4:1], imm[11], 7'b0};
                end
            end
            FMT_S: begin
                if (!fits12) begin
                    err = ERR_RANGE;
                end else begin
                    word = op.base | {imm[11:5], req.src2_reg, req.src1_reg, 3'b0,
                                      imm[4:0], 7'b0};
                end
            end
            FMT_R: begin
                word = op.base | {7'b0, req.src2_reg, req.src1_reg, 3'b0,
                                  req.dest_reg, 7'b0};
            end
            FMT_FENCE: begin
                word = op.base | {4'b0, req.fence_pred, req.fence_succ, 20'b0};
            end
            default: begin
                word = op.base;
            end
        endcase
        if (err != ERR_OK) begin
            word = '0;
        end
    end

    assign res.machine_word = word;
    assign res.error_code   = err;

endmodule

`default_nettype wire

@@ rtl/core/rv32i_instruction_encoder.sv @@
// RV32I instruction encoder top level: request register, encoder, result register.
// Depends on rv32ienc_pkg and rv32ienc_encode.
//
// Usage:
//   Slave channel s_axis_* carries one parsed instruction per request; the
//   master channel m_axis_* returns its 32-bit machine word and error code.
//   Both use a tvalid/tready handshake; a request moves when both are high.
//   Path: an accepted request is held in the request register, then in the
//   result register, which drives m_axis_tvalid.
//   Throughput: one request per cycle while m_axis_tready is high, set by the
//   single encoder pass between the two registers.
//   Stall: while m_axis_tready is low the result register holds its word and
//   the request register holds one more request, so at most two requests sit
//   inside; s_axis_tready drops only when both are full.
//   Reset: aresetn low for one clock empties both registers; no other state.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_instruction_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [5:0] command, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
    // [52:21] immediate, [56:53] fence_pred, [60:57] fence_succ, [63:61] zero
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] machine_word, [33:32] error_code, [39:34] zero
    output logic [39:0]      m_axis_tdata
);
    import rv32ienc_pkg::*;

    logic     req_valid_reg;
    request_t req_reg;
    logic     res_valid_reg;
    result_t  res_reg;
    result_t  res_next;
    logic     res_load;
    logic     req_load;

    assign res_load      = req_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !req_valid_reg || res_load;
    assign req_load      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            req_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_load) begin
            req_reg <= request_t'(s_axis_tdata[$bits(request_t)-1:0]);
        end
    end

    rv32ienc_encode u_encode (
        .req (req_reg),
        .res (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_load) begin
            res_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {6'b0, res_reg};

endmodule

`default_nettype wire

@@ rtl/core/rv32ienc_checker.sv @@
// Port-level checks for rv32i_instruction_encoder, bound to the top level.
// Depends on rv32ienc_pkg for the error codes.
`timescale 1ns / 1ps
`default_nettype none

module rv32ienc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import rv32ienc_pkg::*;

    logic [1:0] res_err;
    assign res_err = m_axis_tdata[33:32];

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res_err == ERR_OK || res_err == ERR_RANGE
                           || res_err == ERR_ALIGN))
        else $error("undefined error code");

    a_err_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && res_err != ERR_OK) |-> (m_axis_tdata[31:0] == 32'h0))
        else $error("non-zero word with error");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_accept_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid && !s_axis_tready) |-> 1'b0)
        else $error("request refused while result register empty");

endmodule

bind rv32i_instruction_encoder rv32ienc_checker u_rv32ienc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
